>>> rtl/wpma_pkg.sv
// Shared constants, types and helpers for the window pooling unit.
// No dependencies; every other file imports this package.
package wpma_pkg;

    localparam int VALUE_WIDTH     = 32;
    localparam int MAX_WINDOW_SIDE = 16;
    localparam int SIDE_W          = $clog2(MAX_WINDOW_SIDE);
    localparam int CFG_W           = 5;
    localparam int CFG_IDX_W       = 2;
    localparam int COUNT_W         = 2 * SIDE_W + 1;
    localparam int SUM_W           = VALUE_WIDTH + 2 * SIDE_W;
    localparam int STEP_W          = $clog2(SUM_W);
    localparam int QUEUE_DEPTH     = 2;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ROWS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COLS = CFG_IDX_W'(1);
    localparam logic [CFG_W-1:0]     SIDE_RESET      = CFG_W'(2);

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] max_value;
        logic [SIDE_W-1:0]             max_row;
        logic [SIDE_W-1:0]             max_col;
        logic signed [SUM_W-1:0]       sum;
        logic [COUNT_W-1:0]            count;
    } t_job;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_HOLD
    } t_div_state;

    function automatic logic [CFG_W-1:0] side_of(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CFG_W'(1);
        end else if (v > CFG_W'(MAX_WINDOW_SIDE)) begin
            r = CFG_W'(MAX_WINDOW_SIDE);
        end
        return r;
    endfunction

endpackage

>>> rtl/wpma_front.sv
// Front end: window configuration, running max/argmax and exact sum.
// Pushes one finished-window job per window. Depends on wpma_pkg.
module wpma_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wpma_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [wpma_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [wpma_pkg::VALUE_WIDTH-1:0] i_sample_value,
    output logic                              o_job_valid,
    input  logic                              i_job_ready,
    output wpma_pkg::t_job                    o_job
);
    import wpma_pkg::*;

    logic [CFG_W-1:0]              r_rows_cfg, r_cols_cfg;
    logic signed [VALUE_WIDTH-1:0] r_max, n_max;
    logic [SIDE_W-1:0]             r_brow, n_brow, r_bcol, n_bcol;
    logic signed [SUM_W-1:0]       r_sum, n_sum;
    logic [SIDE_W-1:0]             r_row, r_col;
    logic [CFG_W-1:0]              rows, cols;
    logic                          accept, first, take, last_col, last_row;

    assign rows       = side_of(r_rows_cfg);
    assign cols       = side_of(r_cols_cfg);
    assign o_in_ready = i_job_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign first      = (r_row == '0) && (r_col == '0);
    assign take       = first || (i_sample_value > r_max);
    assign last_col   = (CFG_W'(r_col) + CFG_W'(1)) == cols;
    assign last_row   = (CFG_W'(r_row) + CFG_W'(1)) == rows;

    always_comb begin
        n_max  = take ? i_sample_value : r_max;
        n_brow = take ? r_row : r_brow;
        n_bcol = take ? r_col : r_bcol;
        n_sum  = r_sum + {{(SUM_W-VALUE_WIDTH){i_sample_value[VALUE_WIDTH-1]}},
                          i_sample_value};
    end

    assign o_job_valid     = accept && last_col && last_row;
    assign o_job.max_value = n_max;
    assign o_job.max_row   = n_brow;
    assign o_job.max_col   = n_bcol;
    assign o_job.sum       = n_sum;
    assign o_job.count     = COUNT_W'(rows) * COUNT_W'(cols);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= SIDE_RESET;
            r_cols_cfg <= SIDE_RESET;
            r_max      <= '0;
            r_brow     <= '0;
            r_bcol     <= '0;
            r_sum      <= '0;
            r_row      <= '0;
            r_col      <= '0;
        end else if (i_cfg_we &&
                     (i_cfg_index == REG_WINDOW_ROWS || i_cfg_index == REG_WINDOW_COLS)) begin
            if (i_cfg_index == REG_WINDOW_ROWS) begin
                r_rows_cfg <= i_cfg_data;
            end else begin
                r_cols_cfg <= i_cfg_data;
            end
            // drop any partial window
            r_max  <= '0;
            r_brow <= '0;
            r_bcol <= '0;
            r_sum  <= '0;
            r_row  <= '0;
            r_col  <= '0;
        end else if (accept) begin
            if (last_col && last_row) begin
                r_max  <= '0;
                r_brow <= '0;
                r_bcol <= '0;
                r_sum  <= '0;
                r_row  <= '0;
                r_col  <= '0;
            end else begin
                r_max  <= n_max;
                r_brow <= n_brow;
                r_bcol <= n_bcol;
                r_sum  <= n_sum;
                if (last_col) begin
                    r_col <= '0;
                    r_row <= r_row + SIDE_W'(1);
                end else begin
                    r_col <= r_col + SIDE_W'(1);
                end
            end
        end
    end

endmodule

>>> rtl/wpma_queue.sv
// Two-entry job queue between the front end and the divider.
// Depends on wpma_pkg for the job type and depth.
module wpma_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  wpma_pkg::t_job i_push_job,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output wpma_pkg::t_job o_pop_job
);
    import wpma_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              push, pop;

    assign o_push_ready = r_cnt != QCNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_cnt != '0;
    assign o_pop_job    = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

>>> rtl/wpma_div.sv
// Back end: restoring divider, one quotient bit per cycle, and result register.
// Depends on wpma_pkg for the job type and divider state enum.
module wpma_div (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_job_valid,
    output logic                                    o_job_ready,
    input  wpma_pkg::t_job                          i_job,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [wpma_pkg::VALUE_WIDTH-1:0] o_max_value,
    output logic [wpma_pkg::SIDE_W-1:0]             o_max_row,
    output logic [wpma_pkg::SIDE_W-1:0]             o_max_col,
    output logic signed [wpma_pkg::VALUE_WIDTH-1:0] o_average_value
);
    import wpma_pkg::*;

    t_div_state                    r_state, n_state;
    logic [STEP_W-1:0]             r_step, n_step;
    logic [COUNT_W-1:0]            r_rem, n_rem, r_div, n_div;
    logic [SUM_W-1:0]              r_quo, n_quo;
    logic                          r_neg, n_neg;
    logic signed [VALUE_WIDTH-1:0] r_max, n_max;
    logic [SIDE_W-1:0]             r_row, n_row, r_col, n_col;
    logic                          r_out_valid, n_out_valid;
    logic signed [VALUE_WIDTH-1:0] r_out_max, n_out_max, r_out_avg, n_out_avg;
    logic [SIDE_W-1:0]             r_out_row, n_out_row, r_out_col, n_out_col;
    logic [COUNT_W:0]              rem_sh, diff;
    logic                          ge;
    logic [SUM_W-1:0]              quo_signed;

    assign rem_sh     = {r_rem, r_quo[SUM_W-1]};
    assign ge         = rem_sh >= {1'b0, r_div};
    assign diff       = rem_sh - {1'b0, r_div};
    assign quo_signed = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
    assign o_job_ready = r_state == DIV_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= DIV_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step    <= n_step;
        r_rem     <= n_rem;
        r_div     <= n_div;
        r_quo     <= n_quo;
        r_neg     <= n_neg;
        r_max     <= n_max;
        r_row     <= n_row;
        r_col     <= n_col;
        r_out_max <= n_out_max;
        r_out_avg <= n_out_avg;
        r_out_row <= n_out_row;
        r_out_col <= n_out_col;
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_rem       = r_rem;
        n_div       = r_div;
        n_quo       = r_quo;
        n_neg       = r_neg;
        n_max       = r_max;
        n_row       = r_row;
        n_col       = r_col;
        n_out_valid = r_out_valid;
        n_out_max   = r_out_max;
        n_out_avg   = r_out_avg;
        n_out_row   = r_out_row;
        n_out_col   = r_out_col;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            DIV_IDLE: begin
                if (i_job_valid) begin
                    n_max   = i_job.max_value;
                    n_row   = i_job.max_row;
                    n_col   = i_job.max_col;
                    n_div   = i_job.count;
                    n_neg   = i_job.sum[SUM_W-1];
                    n_quo   = i_job.sum[SUM_W-1] ? (~i_job.sum + SUM_W'(1)) : i_job.sum;
                    n_rem   = '0;
                    n_step  = '0;
                    n_state = DIV_RUN;
                end
            end
            DIV_RUN: begin
                n_rem  = ge ? diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
                n_quo  = {r_quo[SUM_W-2:0], ge};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = DIV_HOLD;
                end
            end
            DIV_HOLD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_max   = r_max;
                    n_out_row   = r_row;
                    n_out_col   = r_col;
                    n_out_avg   = quo_signed[VALUE_WIDTH-1:0];
                    n_state     = DIV_IDLE;
                end
            end
            default: begin
                n_state = DIV_IDLE;
            end
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_max_value     = r_out_max;
    assign o_max_row       = r_out_row;
    assign o_max_col       = r_out_col;
    assign o_average_value = r_out_avg;

endmodule

>>> rtl/window_pooling_max_avg.sv
// Top level of the window pooling unit: max with argmax and truncated average.
// Depends on wpma_pkg, wpma_front, wpma_queue and wpma_div.
//
//   channel   handshake                   payload
//   input     i_in_valid / o_in_ready     i_sample_value
//   result    o_out_valid / i_out_ready   o_max_value, o_max_row, o_max_col, o_average_value
//   config    i_cfg_we                    i_cfg_index, i_cfg_data
//
// The front end takes one sample per cycle while the two-entry job queue has room.
// Each window is divided in the restoring divider, one quotient bit per step. The divider
// takes the next job only once it has handed its result to the free result register, so
// the front end waits while the two-entry queue is full. Reset is synchronous; both window
// sides return to 2. A write to the rows or columns register clears any partial window.
module window_pooling_max_avg (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_we,
    input  logic [wpma_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [wpma_pkg::CFG_W-1:0]              i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [wpma_pkg::VALUE_WIDTH-1:0] i_sample_value,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [wpma_pkg::VALUE_WIDTH-1:0] o_max_value,
    output logic [wpma_pkg::SIDE_W-1:0]             o_max_row,
    output logic [wpma_pkg::SIDE_W-1:0]             o_max_col,
    output logic signed [wpma_pkg::VALUE_WIDTH-1:0] o_average_value
);
    import wpma_pkg::*;

    t_job push_job, pop_job;
    logic push_valid, push_ready, pop_valid, pop_ready;

    wpma_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_sample_value (i_sample_value),
        .o_job_valid    (push_valid),
        .i_job_ready    (push_ready),
        .o_job          (push_job)
    );

    wpma_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_job   (push_job),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_job    (pop_job)
    );

    wpma_div u_div (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job_valid     (pop_valid),
        .o_job_ready     (pop_ready),
        .i_job           (pop_job),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_max_value     (o_max_value),
        .o_max_row       (o_max_row),
        .o_max_col       (o_max_col),
        .o_average_value (o_average_value)
    );

endmodule
